/* rtl/dnv_pkg.sv */
// ----------------------------------------------------------------------------
// dnv_pkg
// Shared types and constants for the dotted note value splitter: the item
// formats on both channels and the fixed geometry of the tick scan.
// ----------------------------------------------------------------------------
package dnv_pkg;

  // field widths of the items
  localparam int TICK_W  = 16;
  localparam int NOTE_W  = 4;
  localparam int DOT_W   = 3;
  localparam int ENTRY_W = NOTE_W + DOT_W;

  // tick bits: a breve pair per 4096 ticks, scan from the breve bit to the 1/128 bit
  localparam int BREVE_PAIR_BIT = 12;
  localparam int SCAN_TOP       = 11;
  localparam int SCAN_LOW       = 3;
  localparam int SCAN_BITS      = SCAN_TOP - SCAN_LOW + 1;
  localparam int SLOT_W         = $clog2(SCAN_BITS);

  // note value codes
  localparam logic [NOTE_W-1:0] NOTE_BREVE = 4'd0;
  localparam logic [NOTE_W-1:0] NOTE_LAST  = 4'd8;

  typedef struct packed {
    logic [TICK_W-1:0] duration_ticks;
    logic              long_first;
    logic [DOT_W-1:0]  dot_limit;
  } in_item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note_value;
    logic [DOT_W-1:0]  dot_count;
    logic              last;
  } out_item_t;

endpackage

/* rtl/duration_to_dotted_note_values.sv */
// ----------------------------------------------------------------------------
// duration_to_dotted_note_values
// Splits a duration in ticks (quarter note 256 ticks) into plain breves and
// dotted note values, emitted longest first or in reverse.
// ----------------------------------------------------------------------------
// Usage:
//   An item (duration, order flag, dot limit) is taken on a clock edge with
//   start high and busy low. Busy rises only when the two-entry job queue
//   is full, so two items can wait while a third is being worked on.
//   Results appear on out_item for one cycle each with out_strobe high, on
//   consecutive cycles, the final one flagged by last. An item that leaves
//   nothing after the low tick bits are dropped gives no result at all.
// Operation:
//   the back end takes a job, scans the nine tick bits (one tick bit per
//   cycle), then emits its N results one per cycle, N <= 39 at the default
//   sizes; the dotted notes come from the note buffer read port, the
//   breves do not. It takes no new job until the last result is out.
//   The receiver cannot hold results off; results are never stalled.
// Reset:
//   synchronous, active low; clears the queue and the sequencer, no result
//   is in flight afterwards. The note buffer needs no clearing.
// ----------------------------------------------------------------------------
module duration_to_dotted_note_values import dnv_pkg::*; #(
  parameter int DURATION_BITS = 16,
  parameter int BUFFER_DEPTH  = 64,
  parameter int MAX_DOTS      = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int CW      = $clog2(BUFFER_DEPTH + 1);
  localparam int DESC_W  = 1 + DOT_W + SCAN_BITS + CW;
  localparam int Q_DEPTH = 2;

  logic              push;
  logic [DESC_W-1:0] front_desc;
  logic              q_full;
  logic              q_valid;
  logic [DESC_W-1:0] q_head;
  logic              q_pop;

  // classify incoming items
  dnv_front #(
    .DURATION_BITS (DURATION_BITS),
    .BUFFER_DEPTH  (BUFFER_DEPTH),
    .MAX_DOTS      (MAX_DOTS)
  ) u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .desc    (front_desc)
  );

  // job queue between front and back
  dnv_queue #(
    .WIDTH (DESC_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // scan and emit
  dnv_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

/* rtl/dnv_front.sv */
// ----------------------------------------------------------------------------
// dnv_front
// Accepts items and classifies them: masks the duration, counts the plain
// breves (clamped to the buffer depth), extracts the scan bits and clamps
// the dot limit, then packs a job descriptor for the queue.
// ----------------------------------------------------------------------------
module dnv_front import dnv_pkg::*; #(
  parameter int DURATION_BITS = 16,
  parameter int BUFFER_DEPTH  = 64,
  parameter int MAX_DOTS      = 4,
  localparam int CW     = $clog2(BUFFER_DEPTH + 1),
  localparam int DESC_W = 1 + DOT_W + SCAN_BITS + CW
) (
  input  logic              start,
  input  in_item_t          in_item,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output logic [DESC_W-1:0] desc
);

  localparam int MASK_BITS = (DURATION_BITS < TICK_W) ? DURATION_BITS : TICK_W;
  localparam int PAIR_W    = TICK_W - BREVE_PAIR_BIT;

  logic [TICK_W-1:0] tick_mask;
  logic [TICK_W-1:0] ticks;
  logic [PAIR_W:0]   breves;
  logic [CW-1:0]     breves_c;
  logic [DOT_W-1:0]  limit;

  // handshake: take an item whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // duration masking and breve count
  assign tick_mask = TICK_W'((33'd1 << MASK_BITS) - 33'd1);
  assign ticks     = in_item.duration_ticks & tick_mask;
  assign breves    = {ticks[TICK_W-1:BREVE_PAIR_BIT], 1'b0};

  // clamp breves to the buffer and dots to the maximum
  always_comb begin
    if (32'(breves) > 32'(BUFFER_DEPTH)) begin
      breves_c = CW'(BUFFER_DEPTH);
    end else begin
      breves_c = CW'(breves);
    end
    if ({1'b0, in_item.dot_limit} > 4'(MAX_DOTS)) begin
      limit = DOT_W'(MAX_DOTS);
    end else begin
      limit = in_item.dot_limit;
    end
  end

  // descriptor layout: long_first, limit, scan bits, breve count
  assign desc = {in_item.long_first, limit, ticks[SCAN_TOP:SCAN_LOW], breves_c};

endmodule

/* rtl/dnv_queue.sv */
// ----------------------------------------------------------------------------
// dnv_queue
// Small register queue that holds job descriptors between the front and
// the back, so the front can take a new item while the back is working.
// ----------------------------------------------------------------------------
module dnv_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full      = (fill_r == CNT_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // descriptor storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/dnv_back.sv */
// ----------------------------------------------------------------------------
// dnv_back
// Carries out one job at a time: scans the nine duration bits one per
// cycle into a small note buffer, then emits the breves and buffered notes
// one per cycle, longest first or reversed, with a registered buffer read.
// ----------------------------------------------------------------------------
module dnv_back import dnv_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  localparam int CW     = $clog2(BUFFER_DEPTH + 1),
  localparam int DESC_W = 1 + DOT_W + SCAN_BITS + CW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [DESC_W-1:0] q_desc,
  output logic              q_pop,
  output logic              out_strobe,
  output out_item_t         out_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [SCAN_BITS-1:0] bits_r, bits_nxt;
  logic [CW-1:0]        nbrev_r, nbrev_nxt;
  logic [DOT_W-1:0]     limit_r, limit_nxt;
  logic                 long_first_r, long_first_nxt;
  logic [NOTE_W-1:0]    level_r, level_nxt;
  logic [SLOT_W-1:0]    k_r, k_nxt;
  logic                 seek_r, seek_nxt;
  logic [DOT_W-1:0]     dots_left_r, dots_left_nxt;
  logic                 stored_r, stored_nxt;
  logic [NOTE_W-1:0]    cur_val_r, cur_val_nxt;
  logic [DOT_W-1:0]     cur_dots_r, cur_dots_nxt;
  logic [SLOT_W-1:0]    cur_slot_r, cur_slot_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 ov_r, ov_nxt;
  logic                 obreve_r, obreve_nxt;
  logic                 olast_r, olast_nxt;

  // note buffer
  logic [ENTRY_W-1:0] buf_mem [SCAN_BITS];
  logic [ENTRY_W-1:0] rdata_r;
  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0] wdata;

  logic          set_bit;
  logic          room;
  logic [CW-1:0] pos;

  assign set_bit = bits_r[SCAN_BITS-1];
  assign room    = ((CW+1)'(nbrev_r) + (CW+1)'(k_r)) < (CW+1)'(BUFFER_DEPTH);
  assign pos     = long_first_r ? idx_r : (count_r - CW'(1) - idx_r);

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    bits_nxt       = bits_r;
    nbrev_nxt      = nbrev_r;
    limit_nxt      = limit_r;
    long_first_nxt = long_first_r;
    level_nxt      = level_r;
    k_nxt          = k_r;
    seek_nxt       = seek_r;
    dots_left_nxt  = dots_left_r;
    stored_nxt     = stored_r;
    cur_val_nxt    = cur_val_r;
    cur_dots_nxt   = cur_dots_r;
    cur_slot_nxt   = cur_slot_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ov_nxt         = 1'b0;
    obreve_nxt     = obreve_r;
    olast_nxt      = olast_r;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = k_r;
    wdata          = '0;
    raddr          = SLOT_W'(pos - nbrev_r);
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          {long_first_nxt, limit_nxt, bits_nxt, nbrev_nxt} = q_desc;
          level_nxt  = '0;
          k_nxt      = '0;
          seek_nxt   = 1'b1;
          stored_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one tick bit per cycle, breve end first
        if (seek_r) begin
          if (set_bit) begin
            stored_nxt    = room;
            cur_val_nxt   = level_r;
            cur_dots_nxt  = '0;
            cur_slot_nxt  = k_r;
            dots_left_nxt = limit_r;
            seek_nxt      = (limit_r == '0);
            if (room) begin
              we    = 1'b1;
              waddr = k_r;
              wdata = {DOT_W'(0), level_r};
              k_nxt = k_r + SLOT_W'(1);
            end
          end
        end else if (set_bit) begin
          if (stored_r) begin
            cur_dots_nxt = cur_dots_r + DOT_W'(1);
            we           = 1'b1;
            waddr        = cur_slot_r;
            wdata        = {cur_dots_r + DOT_W'(1), cur_val_r};
          end
          dots_left_nxt = dots_left_r - DOT_W'(1);
          seek_nxt      = (dots_left_r == DOT_W'(1));
        end else begin
          seek_nxt = 1'b1;
        end
        bits_nxt  = bits_r << 1;
        level_nxt = level_r + NOTE_W'(1);
        if (level_r == NOTE_W'(SCAN_BITS - 1)) begin
          count_nxt = nbrev_r + CW'(k_nxt);
          idx_nxt   = '0;
          state_nxt = (count_nxt != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        // one result per cycle, buffer read lands with the strobe
        ov_nxt     = 1'b1;
        obreve_nxt = (pos < nbrev_r);
        olast_nxt  = (idx_r == count_r - CW'(1));
        idx_nxt    = idx_r + CW'(1);
        if (idx_r == count_r - CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    bits_r       <= bits_nxt;
    nbrev_r      <= nbrev_nxt;
    limit_r      <= limit_nxt;
    long_first_r <= long_first_nxt;
    level_r      <= level_nxt;
    k_r          <= k_nxt;
    seek_r       <= seek_nxt;
    dots_left_r  <= dots_left_nxt;
    stored_r     <= stored_nxt;
    cur_val_r    <= cur_val_nxt;
    cur_dots_r   <= cur_dots_nxt;
    cur_slot_r   <= cur_slot_nxt;
    count_r      <= count_nxt;
    idx_r        <= idx_nxt;
    obreve_r     <= obreve_nxt;
    olast_r      <= olast_nxt;
  end

  // buffer write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      buf_mem[waddr] <= wdata;
    end
    rdata_r <= buf_mem[raddr];
  end

  // result: breves carry no dots
  assign out_strobe          = ov_r;
  assign out_item.note_value = obreve_r ? NOTE_BREVE : rdata_r[NOTE_W-1:0];
  assign out_item.dot_count  = obreve_r ? DOT_W'(0) : rdata_r[ENTRY_W-1:NOTE_W];
  assign out_item.last       = olast_r;

endmodule

/* rtl/dnv_checker.sv */
// ----------------------------------------------------------------------------
// dnv_checker
// Port-level checks for the dotted note value splitter, bound to the top
// level.
// ----------------------------------------------------------------------------
module dnv_checker import dnv_pkg::*; #(
  parameter int MAX_DOTS = 4
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // no result right after a reset edge
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // busy only rises after an item is taken
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // note values and dots stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.note_value <= NOTE_LAST) &&
                   ({1'b0, out_item.dot_count} <= 4'(MAX_DOTS)))
    else $error("result field out of range");

  // results of one item come on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside a result burst");

endmodule

bind duration_to_dotted_note_values dnv_checker #(
  .MAX_DOTS (MAX_DOTS)
) u_dnv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
